// ----- rtl/rle_pkg.sv -----
package rle_pkg;

  // Default limits and fixed field widths
  localparam int MAX_RUN_DEF = 127;
  localparam int MAX_LIT_DEF = 60;
  localparam int CQ_DEPTH    = 4;
  localparam int RUN_CW      = 7;

  // Packet header codes
  localparam logic [7:0] HDR_LIT = 8'd128;
  localparam logic [7:0] HDR_ONE = 8'd129;

  // Literal store address and count widths
  function automatic int lit_aw(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int lit_cw(input int depth);
    return $clog2(depth + 1);
  endfunction

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_last;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       code_last;
  } out_t;

  // At most one command per classified byte: optional literal append, optional
  // literal flush, then up to two header/byte pairs (the second with a
  // lone-byte header).
  typedef struct packed {
    logic       store_en;
    logic [7:0] store_byte;
    logic       flush_en;
    logic       p0_en;
    logic [7:0] p0_hdr;
    logic [7:0] p0_byte;
    logic       p1_en;
    logic [7:0] p1_byte;
    logic       last;
  } cmd_t;

endpackage

// ----- rtl/rle_front.sv -----
module rle_front
  import rle_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF,
  parameter int MAX_LIT = MAX_LIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic item_accept,
  input  in_t  item,
  output logic cmd_push,
  output cmd_t cmd
);

  localparam int LIT_CW = lit_cw(MAX_LIT);
  localparam logic [RUN_CW-1:0] MaxRunC = RUN_CW'(MAX_RUN);
  localparam logic [LIT_CW-1:0] MaxLitC = LIT_CW'(MAX_LIT);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RUN  = 3'b010,
    F_LIT  = 3'b100
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          held_sym_r, held_sym_nxt;
  logic [RUN_CW-1:0]   held_cnt_r, held_cnt_nxt;
  logic [LIT_CW-1:0]   lit_cnt_r, lit_cnt_nxt;
  logic [LIT_CW-1:0]   lc_inc;
  logic [7:0]          b;
  logic                last;

  assign b      = item.data_byte;
  assign last   = item.msg_last;
  assign lc_inc = lit_cnt_r + 1'b1;

  // Classify the accepted byte against the held byte
  always_comb begin
    phase_nxt    = phase_r;
    held_sym_nxt = held_sym_r;
    held_cnt_nxt = held_cnt_r;
    lit_cnt_nxt  = lit_cnt_r;
    cmd          = '0;
    cmd.last     = last;
    if (item_accept) begin
      case (phase_r)
        F_LIT: begin
          if (held_sym_r != b) begin
            // absorb the held byte into the literal block
            cmd.store_en   = 1'b1;
            cmd.store_byte = held_sym_r;
            if (lc_inc >= MaxLitC || last) begin
              cmd.flush_en = 1'b1;
              lit_cnt_nxt  = '0;
              if (last) begin
                cmd.p0_en   = 1'b1;
                cmd.p0_hdr  = HDR_ONE;
                cmd.p0_byte = b;
                phase_nxt   = F_IDLE;
              end else begin
                held_sym_nxt = b;
                held_cnt_nxt = RUN_CW'(1);
                phase_nxt    = F_RUN;
              end
            end else begin
              held_sym_nxt = b;
              lit_cnt_nxt  = lc_inc;
            end
          end else begin
            // held byte repeats: close the block and open a run of two
            cmd.flush_en = 1'b1;
            lit_cnt_nxt  = '0;
            held_cnt_nxt = RUN_CW'(2);
            if (last) begin
              cmd.p0_en   = 1'b1;
              cmd.p0_hdr  = 8'd2;
              cmd.p0_byte = held_sym_r;
              phase_nxt   = F_IDLE;
            end else begin
              phase_nxt = F_RUN;
            end
          end
        end
        F_RUN: begin
          if (b == held_sym_r && held_cnt_r < MaxRunC) begin
            // extend the run
            held_cnt_nxt = held_cnt_r + 1'b1;
            if (last) begin
              cmd.p0_en   = 1'b1;
              cmd.p0_hdr  = {1'b0, held_cnt_r} + 8'd1;
              cmd.p0_byte = held_sym_r;
              phase_nxt   = F_IDLE;
            end
          end else if (b == held_sym_r || held_cnt_r >= RUN_CW'(2)) begin
            // close the run, start a new packet
            cmd.p0_en   = 1'b1;
            cmd.p0_hdr  = {1'b0, held_cnt_r};
            cmd.p0_byte = held_sym_r;
            if (last) begin
              cmd.p1_en   = 1'b1;
              cmd.p1_byte = b;
              phase_nxt   = F_IDLE;
            end else begin
              held_sym_nxt = b;
              held_cnt_nxt = RUN_CW'(1);
            end
          end else begin
            // single byte: it opens a literal block
            cmd.store_en   = 1'b1;
            cmd.store_byte = held_sym_r;
            if (LIT_CW'(1) >= MaxLitC || last) begin
              cmd.flush_en = 1'b1;
              lit_cnt_nxt  = '0;
              if (last) begin
                cmd.p0_en   = 1'b1;
                cmd.p0_hdr  = HDR_ONE;
                cmd.p0_byte = b;
                phase_nxt   = F_IDLE;
              end else begin
                held_sym_nxt = b;
                held_cnt_nxt = RUN_CW'(1);
              end
            end else begin
              held_sym_nxt = b;
              lit_cnt_nxt  = LIT_CW'(1);
              phase_nxt    = F_LIT;
            end
          end
        end
        default: begin
          // start a packet from idle
          if (last) begin
            cmd.p0_en   = 1'b1;
            cmd.p0_hdr  = HDR_ONE;
            cmd.p0_byte = b;
            phase_nxt   = F_IDLE;
          end else begin
            held_sym_nxt = b;
            held_cnt_nxt = RUN_CW'(1);
            phase_nxt    = F_RUN;
          end
        end
      endcase
    end
  end

  assign cmd_push = item_accept && (cmd.store_en || cmd.flush_en || cmd.p0_en);

  // Hold coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= F_IDLE;
      held_sym_r <= '0;
      held_cnt_r <= '0;
      lit_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      held_sym_r <= held_sym_nxt;
      held_cnt_r <= held_cnt_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
    end
  end

  a_lit_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == F_LIT |-> (lit_cnt_r != '0 && lit_cnt_r < MaxLitC))
    else $error("literal count out of range while block open");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (item_accept && last) |=> phase_r == F_IDLE)
    else $error("coder left state pending after message end");

endmodule

// ----- rtl/rle_cmd_fifo.sv -----
module rle_cmd_fifo
  import rle_pkg::*;
#(
  parameter int DEPTH = CQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> !full)
    else $error("command queue still full after a pop");

endmodule

// ----- rtl/rle_back.sv -----
module rle_back
  import rle_pkg::*;
#(
  parameter int MAX_LIT = MAX_LIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cq_head,
  input  logic cq_empty,
  output logic cq_pop,
  output out_t out_item,
  output logic out_valid,
  input  logic out_take
);

  localparam int LIT_AW = lit_aw(MAX_LIT);
  localparam int LIT_CW = lit_cw(MAX_LIT);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_FHDR = 7'b0000010,
    B_FDAT = 7'b0000100,
    B_P0H  = 7'b0001000,
    B_P0B  = 7'b0010000,
    B_P1H  = 7'b0100000,
    B_P1B  = 7'b1000000
  } bstate_t;

  bstate_t             state_r, state_nxt;
  cmd_t                cur_r, cur_nxt;
  logic [LIT_CW-1:0]   lit_cnt_r, lit_cnt_nxt;
  logic [LIT_CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [LIT_CW-1:0]   idx_inc;
  logic [7:0]          rd_q_r;
  logic [7:0]          lit_mem [MAX_LIT];
  logic                mem_we, rd_en;
  logic [LIT_AW-1:0]   rd_addr;
  logic                out_valid_r;
  out_t                out_r, out_load_val;
  logic                out_load, can_put;

  assign can_put = !out_valid_r || out_take;
  assign idx_inc = rd_idx_r + 1'b1;

  // Sequence the commands into coded bytes
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    lit_cnt_nxt  = lit_cnt_r;
    rd_idx_nxt   = rd_idx_r;
    cq_pop       = 1'b0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    out_load     = 1'b0;
    out_load_val = '0;
    case (state_r)
      B_IDLE: begin
        if (!cq_empty) begin
          cq_pop  = 1'b1;
          cur_nxt = cq_head;
          if (cq_head.store_en) begin
            mem_we      = 1'b1;
            lit_cnt_nxt = lit_cnt_r + 1'b1;
          end
          if (cq_head.flush_en)   state_nxt = B_FHDR;
          else if (cq_head.p0_en) state_nxt = B_P0H;
          else                    state_nxt = B_IDLE;
        end
      end
      B_FHDR: begin
        if (can_put) begin
          out_load     = 1'b1;
          out_load_val = '{code_byte: HDR_LIT + 8'(lit_cnt_r), code_last: 1'b0};
          rd_en        = 1'b1;
          rd_idx_nxt   = '0;
          state_nxt    = B_FDAT;
        end
      end
      B_FDAT: begin
        if (can_put) begin
          out_load     = 1'b1;
          out_load_val = '{code_byte: rd_q_r, code_last: 1'b0};
          if (idx_inc == lit_cnt_r) begin
            lit_cnt_nxt = '0;
            state_nxt   = cur_r.p0_en ? B_P0H : B_IDLE;
          end else begin
            // prefetch the next literal byte
            rd_idx_nxt = idx_inc;
            rd_en      = 1'b1;
            rd_addr    = idx_inc[LIT_AW-1:0];
          end
        end
      end
      B_P0H: begin
        if (can_put) begin
          out_load     = 1'b1;
          out_load_val = '{code_byte: cur_r.p0_hdr, code_last: 1'b0};
          state_nxt    = B_P0B;
        end
      end
      B_P0B: begin
        if (can_put) begin
          out_load     = 1'b1;
          out_load_val = '{code_byte: cur_r.p0_byte,
                           code_last: cur_r.last && !cur_r.p1_en};
          state_nxt    = cur_r.p1_en ? B_P1H : B_IDLE;
        end
      end
      B_P1H: begin
        if (can_put) begin
          out_load     = 1'b1;
          out_load_val = '{code_byte: HDR_ONE, code_last: 1'b0};
          state_nxt    = B_P1B;
        end
      end
      B_P1B: begin
        if (can_put) begin
          out_load     = 1'b1;
          out_load_val = '{code_byte: cur_r.p1_byte, code_last: cur_r.last};
          state_nxt    = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Literal store: append at the fill count, read with registered data
  always_ff @(posedge clk) begin
    if (mem_we) lit_mem[lit_cnt_r[LIT_AW-1:0]] <= cq_head.store_byte;
    if (rd_en)  rd_q_r <= lit_mem[rd_addr];
  end

  // Advance sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      lit_cnt_r <= '0;
      rd_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      lit_cnt_r <= lit_cnt_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Hold the oldest coded byte until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_load_val;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FHDR || state_r == B_FDAT) |-> lit_cnt_r != '0)
    else $error("literal flush with an empty block");

  a_read_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_FDAT |-> rd_idx_r < lit_cnt_r)
    else $error("literal read past the block fill");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_take) |=> $stable(out_r))
    else $error("waiting coded byte overwritten");

endmodule

// ----- rtl/rle_run_literal_encoder.sv -----
// Run/literal byte encoder. Bytes enter through push/full with a flag on the
// last byte of each message; coded bytes (run count or 128 plus literal
// length, then data) leave through empty/pop, with code_last on the final
// coded byte of the message. The front stage takes one byte per cycle while
// its 4-entry command queue has room. The back stage fetches each command,
// then sends its coded bytes through its single output register, waiting
// while that register holds a byte not yet taken; the command fetch and
// this single output register set the sustained rate.
module rle_run_literal_encoder
  import rle_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF,
  parameter int MAX_LIT = MAX_LIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  in_t  in_data,
  output logic full,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  cmd_t cmd, cq_head;
  logic cmd_push, cq_full, cq_empty, cq_pop;
  logic item_accept, out_valid, out_take;

  assign full        = cq_full;
  assign item_accept = push && !cq_full;
  assign empty       = !out_valid;
  assign out_take    = pop && out_valid;

  rle_front #(
    .MAX_RUN(MAX_RUN),
    .MAX_LIT(MAX_LIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_accept(item_accept),
    .item       (in_data),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  rle_cmd_fifo #(
    .DEPTH(CQ_DEPTH)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .head     (cq_head),
    .empty    (cq_empty)
  );

  rle_back #(
    .MAX_LIT(MAX_LIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_head  (cq_head),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .out_item (out_data),
    .out_valid(out_valid),
    .out_take (out_take)
  );

endmodule

// ----- tb/rle_run_literal_encoder_test.sv -----
`timescale 1ns / 100ps

module rle_run_literal_encoder_test;
  import rle_pkg::*;

  localparam int MAX_RUN      = MAX_RUN_DEF;
  localparam int MAX_LIT      = MAX_LIT_DEF;
  localparam int ITEM_TARGET  = 310;
  localparam int HOLD_AT      = 160;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_LIT
  } coder_phase_t;

  typedef logic [7:0] byte_q_t[$];

  // Predict coded bytes from accepted message bytes and check them in order
  class code_predictor;
    coder_phase_t phase;
    logic [7:0]   held_sym;
    int           held_cnt;
    logic [7:0]   lit_store[MAX_LIT];
    int           lit_cnt;
    out_t         expected_codes[$];
    int           bytes_taken;
    int           mismatches;

    function new();
      phase       = PH_IDLE;
      held_sym    = '0;
      held_cnt    = 0;
      lit_cnt     = 0;
      bytes_taken = 0;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction

    function void emit(input logic [7:0] v, input logic last_flag);
      expected_codes.insert(expected_codes.size(), {v, last_flag});
    endfunction

    // Send the open literal block: header, then its bytes
    function void flush_block();
      int n;
      n = (lit_cnt > MAX_LIT) ? MAX_LIT : lit_cnt;
      emit(HDR_LIT + 8'(n), 1'b0);
      for (int i = 0; i < n; i++) emit(lit_store[i], 1'b0);
      lit_cnt = 0;
    endfunction

    // Start a fresh packet with b; a final byte goes out alone
    function void open_packet(input logic [7:0] b, input logic last_flag);
      if (last_flag) begin
        emit(HDR_ONE, 1'b0);
        emit(b, 1'b1);
        phase = PH_IDLE;
      end else begin
        held_sym = b;
        held_cnt = 1;
        phase    = PH_RUN;
      end
    endfunction

    // Append v to the literal block; nb is the byte that follows it
    function void absorb(input logic [7:0] v, input logic [7:0] nb, input logic last_flag);
      if (lit_cnt < MAX_LIT) begin
        lit_store[lit_cnt] = v;
        lit_cnt++;
      end
      if (lit_cnt >= MAX_LIT || last_flag) begin
        flush_block();
        open_packet(nb, last_flag);
      end else begin
        held_sym = nb;
        phase    = PH_LIT;
      end
    endfunction

    function void note_byte(input in_t it);
      logic [7:0] b;
      logic       last_flag;
      logic [7:0] s;
      int         c;
      b         = it.data_byte;
      last_flag = it.msg_last;
      bytes_taken++;

      // Literal phase: keep growing while the pending byte differs from b
      if (phase == PH_LIT) begin
        if (held_sym != b) begin
          absorb(held_sym, b, last_flag);
          return;
        end
        flush_block();
        held_cnt = 1;
        phase    = PH_RUN;
      end

      case (phase)
        PH_RUN: begin
          s = held_sym;
          c = held_cnt;
          if (b == s && c < MAX_RUN) begin
            held_cnt = c + 1;
            if (last_flag) begin
              emit(8'(c + 1), 1'b0);
              emit(s, 1'b1);
              phase = PH_IDLE;
            end
          end else if (b == s || c >= 2) begin
            emit(8'(c), 1'b0);
            emit(s, 1'b0);
            open_packet(b, last_flag);
          end else begin
            lit_cnt = 0;
            absorb(s, b, last_flag);
          end
        end
        default: open_packet(b, last_flag);
      endcase
    endfunction

    task report(input string msg);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_code(input out_t got);
      out_t want;
      if (expected_codes.size() == 0) begin
        report($sformatf("unexpected code byte %0d (last %0b)", got.code_byte, got.code_last));
      end else begin
        want = expected_codes.pop_front();
        if (got.code_byte !== want.code_byte)
          report($sformatf("code_byte expected %0d, got %0d", want.code_byte, got.code_byte));
        if (got.code_last !== want.code_last)
          report($sformatf("code_last expected %0b, got %0b", want.code_last, got.code_last));
      end
    endtask

    task close_out();
      if (expected_codes.size() != 0)
        report($sformatf("%0d code bytes never arrived", expected_codes.size()));
    endtask
  endclass

  logic clk;
  logic rst_n   = 1'b0;
  logic push    = 1'b0;
  in_t  in_data = '0;
  logic full;
  logic empty;
  logic pop     = 1'b0;
  out_t out_data;

  code_predictor pred = new();
  int burst_left = 0;

  rle_run_literal_encoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) pred.note_byte(in_data);
      if (pop && !empty) pred.check_code(out_data);
    end
  end

  // Offer one item, with a random gap before each new burst
  task automatic offer_byte(input logic [7:0] b, input logic last_flag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    push    <= 1'b1;
    in_data <= {b, last_flag};
    do @(posedge clk); while (full);
  endtask

  task automatic send_message(input byte_q_t msg);
    foreach (msg[i]) offer_byte(msg[i], i == msg.size() - 1);
  endtask

  // Drop push and hold until every predicted code byte has come out
  task automatic wait_for_codes();
    @(negedge clk);
    push <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
  endtask

  function automatic byte_q_t build_run(input int len);
    byte_q_t q;
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    repeat (len) q.insert(q.size(), s);
    return q;
  endfunction

  // Every byte differs from its neighbor, so the literal block keeps growing
  function automatic byte_q_t build_literal(input int len);
    byte_q_t q;
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    repeat (len) begin
      q.insert(q.size(), b);
      b = b + 8'($urandom_range(1, 255));
    end
    return q;
  endfunction

  function automatic byte_q_t build_noise();
    byte_q_t q;
    repeat ($urandom_range(1, 16)) q.insert(q.size(), 8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Short runs over a small alphabet, so repeats and singles mix
  function automatic byte_q_t build_mixed();
    byte_q_t q;
    logic [7:0] pool[4];
    logic [7:0] s;
    int target;
    int rl;
    foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
    target = $urandom_range(1, 20);
    while (q.size() < target) begin
      s  = pool[$urandom_range(0, 3)];
      rl = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : $urandom_range(1, 3);
      repeat (rl) if (q.size() < target) q.insert(q.size(), s);
    end
    return q;
  endfunction

  // Receiver: alternate stretches of steady, random, sparse and idle popping
  initial begin : receiver
    int  mode;
    int  stretch;
    bit  held_off;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(4, 40);
      if (!held_off && pred.bytes_taken >= HOLD_AT) begin
        held_off = 1'b1;
        mode     = 4;
        stretch  = HOLD_CYCLES;
      end
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    byte_q_t msg;
    int      n_msg;
    n_msg = 0;
    // Hold reset, then release it at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lone final byte, run closed by the end flag, literal closed by the end flag
    msg = '{8'h00};
    send_message(msg);
    msg = '{8'hFF, 8'hFF};
    send_message(msg);
    msg = '{8'h12, 8'h34, 8'h56};
    send_message(msg);
    // Run, then a single byte turning into a literal, then a closing run
    msg = '{8'h05, 8'h05, 8'h05, 8'h07, 8'h08, 8'h08};
    send_message(msg);
    // Literal cut short by an equal pair
    msg = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h03};
    send_message(msg);
    // Run followed by a lone final byte
    msg = '{8'h09, 8'h09, 8'h04};
    send_message(msg);
    msg = '{8'hAA, 8'h55, 8'hAA, 8'h55};
    send_message(msg);
    wait_for_codes();

    // Run past its cap, then a literal past its cap
    msg = build_run(MAX_RUN + 1);
    send_message(msg);
    msg = build_literal(MAX_LIT + 2);
    send_message(msg);

    while (pred.bytes_taken < ITEM_TARGET) begin
      msg = ($urandom_range(0, 3) == 0) ? build_noise() : build_mixed();
      send_message(msg);
      n_msg++;
      if (n_msg == 4) wait_for_codes();
    end

    // Drain and let the back stage settle
    @(negedge clk);
    push <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    pred.close_out();
    if (pred.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rle_pkg.sv
rtl/rle_front.sv
rtl/rle_cmd_fifo.sv
rtl/rle_back.sv
rtl/rle_run_literal_encoder.sv
tb/rle_run_literal_encoder_test.sv
